### src/usgv_pkg.sv
// Shared types, constants and arithmetic helpers for the UV sphere vertex generator.
// No dependencies; used by usgv_div and uv_sphere_vertex_generator.
`timescale 1ns / 1ps
`default_nettype none

package usgv_pkg;

  // Field widths
  localparam int unsigned IW = 10;      // ring / sector index
  localparam int unsigned CW = 11;      // ring / sector count and divisor
  localparam int unsigned RW = 16;      // radius and widest register
  localparam int unsigned AW = 2;       // register index
  localparam int unsigned MAX_GRID_DIM = 1024;  // largest effective ring / sector count

  // Divider pipeline depth: two quotient bits per stage, 33 bits at most
  localparam int unsigned DIV_SPS = 2;
  localparam int unsigned DIV_LAT = 17;

  // Register map
  localparam logic [AW-1:0] REG_RADIUS  = 2'd0;
  localparam logic [AW-1:0] REG_RINGS   = 2'd1;
  localparam logic [AW-1:0] REG_SECTORS = 2'd2;

  localparam logic [RW-1:0] RADIUS_RST = 16'd128;
  localparam logic [CW-1:0] COUNT_RST  = 11'd32;

  // Quarter-wave sine polynomial, Q30 coefficients
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [31:0] PC1  = 32'd1686629713;
  localparam logic [31:0] PC3  = 32'd693598668;
  localparam logic [31:0] PC5  = 32'd85569306;
  localparam logic [31:0] PC7  = 32'd5026996;
  localparam logic [31:0] PC9  = 32'd172272;
  localparam logic [31:0] PC11 = 32'd3864;
  localparam logic [31:0] HORNER_COEF [5] = '{PC9, PC7, PC5, PC3, PC1};

  typedef struct packed {
    logic [IW-1:0] ring_index;
    logic [IW-1:0] sector_index;
  } in_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [19:0]        vertex_number;
    logic               quad_start;
  } out_t;

  // Fields that ride alongside the math pipeline
  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [19:0] vertex_number;
    logic        quad_start;
  } side_t;

  // Count clamped to [2, mx]
  function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] c, input int unsigned mx);
    logic [CW-1:0] r;
    if (c < CW'(2)) r = CW'(2);
    else if (32'(c) > mx) r = CW'(mx);
    else r = c;
    return r;
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

  // Q30 quarter sine to Q1.15: round, cap, apply sign
  function automatic logic signed [15:0] round_q15(input logic [32:0] qs, input logic neg);
    logic [33:0] t;
    logic [15:0] m;
    t = {1'b0, qs} + 34'd16384;
    if (t[33:15] > 19'd32767) m = 16'd32767;
    else m = t[30:15];
    return neg ? $signed(16'(-m)) : $signed(m);
  endfunction

  // Q1.15 product, rounded half away from zero
  function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic [31:0] p;
    logic [16:0] m;
    p = mag16(a) * mag16(b);
    m = 17'((p + 32'd16384) >> 15);
    return (a[15] ^ b[15]) ? $signed(16'(-m)) : $signed(m[15:0]);
  endfunction

  // Normal times Q8.8 radius, units of 2^-15, saturated to 24 bits
  function automatic logic signed [23:0] scale_pos(input logic signed [15:0] n,
                                                   input logic [RW-1:0] rad);
    logic [31:0] p;
    logic [32:0] t;
    logic [23:0] m;
    p = mag16(n) * rad;
    t = {1'b0, p} + 33'd128;
    if (t[32:8] > 25'd8388607) m = 24'd8388607;
    else m = t[31:8];
    return n[15] ? $signed(24'(-m)) : $signed(m);
  endfunction

endpackage

`default_nettype wire

### src/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator: grid point in, vertex attributes out.
// Depends on usgv_pkg and usgv_div.
`timescale 1ns / 1ps
`default_nettype none

// Takes one (ring, sector) pair per cycle and returns position, unit normal,
// texture coordinates, vertex number and quad-start flag for that grid point.
// Throughput is one vertex per clock while the output accepts results. The
// pipeline runs through the angle dividers (up to 33 quotient bits, two per
// stage), the 8-stage Horner sine units and two product stages. Backpressure
// freezes the whole pipeline; a one-entry skid register keeps the input side
// open for one more transfer while a result waits. Write the configuration
// registers only while the pipeline is empty.
module uv_sphere_vertex_generator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // item input
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  usgv_pkg::in_t           in_data_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output usgv_pkg::out_t          out_data_o,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [usgv_pkg::AW-1:0] cfg_idx_i,
  input  logic [usgv_pkg::RW-1:0] cfg_wdata_i
);

  localparam int unsigned CW     = usgv_pkg::CW;
  localparam int unsigned IW     = usgv_pkg::IW;
  localparam int unsigned RW     = usgv_pkg::RW;
  localparam int unsigned LAT    = usgv_pkg::DIV_LAT;
  localparam int unsigned NST    = LAT + 12;
  localparam int unsigned SIDE_N = LAT + 9;

  // configuration registers
  logic [RW-1:0] radius_q;
  logic [CW-1:0] rings_q, sectors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= usgv_pkg::RADIUS_RST;
      rings_q   <= usgv_pkg::COUNT_RST;
      sectors_q <= usgv_pkg::COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        usgv_pkg::REG_RADIUS:  radius_q  <= cfg_wdata_i;
        usgv_pkg::REG_RINGS:   rings_q   <= cfg_wdata_i[CW-1:0];
        usgv_pkg::REG_SECTORS: sectors_q <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // effective counts and divisors; the user must keep them static while items are in flight (not enforced here)
  logic [CW-1:0] rc, sc, rd, sd;
  assign rc = usgv_pkg::clamp_count(rings_q, usgv_pkg::MAX_GRID_DIM);
  assign sc = usgv_pkg::clamp_count(sectors_q, usgv_pkg::MAX_GRID_DIM);
  assign rd = rc - CW'(1);
  assign sd = sc - CW'(1);

  // pipeline control: everything moves together, skid holds one extra transfer
  logic               en, in_fire, skid_v_q;
  logic [NST-1:0]     vld_q;
  usgv_pkg::in_t      skid_q, in_q;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = !skid_v_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      vld_q    <= '0;
    end else if (en) begin
      skid_v_q <= 1'b0;
      vld_q    <= {vld_q[NST-2:0], skid_v_q | in_valid_i};
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) in_q <= skid_v_q ? skid_q : in_data_i;
    if (!en && in_fire) skid_q <= in_data_i;
  end

  // stage 1: saturate indices, vertex number, quad flag
  logic [IW-1:0] r_c, s_c, r1_q, s1_q;
  logic [20:0]   vn_c;
  logic [19:0]   vn1_q;
  logic          qd1_q;

  assign r_c  = (CW'(in_q.ring_index) > rd) ? rd[IW-1:0] : in_q.ring_index;
  assign s_c  = (CW'(in_q.sector_index) > sd) ? sd[IW-1:0] : in_q.sector_index;
  assign vn_c = 21'(r_c) * 21'(sc) + 21'(s_c);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q  <= r_c;
      s1_q  <= s_c;
      vn1_q <= vn_c[19:0];
      qd1_q <= (CW'(r_c) < rd) && (CW'(s_c) < sd);
    end
  end

  // angle and texture dividers: round(x * 2^K / d) as floor((x*2^K + d/2) / d)
  logic [IW-2:0] hr, hs;
  logic [31:0]   pol_quo;
  logic [32:0]   azi_quo;
  logic [16:0]   tu_quo, tv_quo;

  assign hr = rd[IW-1:1];
  assign hs = sd[IW-1:1];

  usgv_div #(.QB(32), .LAT(LAT)) u_div_pol (
    .clk_i, .en_i(en), .div_i(rd), .rem_i(CW'(r1_q[IW-1:1])),
    .bits_i({r1_q[0], 31'(hr)}), .quo_o(pol_quo)
  );
  usgv_div #(.QB(33), .LAT(LAT)) u_div_azi (
    .clk_i, .en_i(en), .div_i(sd), .rem_i(CW'(s1_q[IW-1:1])),
    .bits_i({s1_q[0], 32'(hs)}), .quo_o(azi_quo)
  );
  usgv_div #(.QB(17), .LAT(LAT)) u_div_tu (
    .clk_i, .en_i(en), .div_i(sd), .rem_i(CW'(s1_q[IW-1:1])),
    .bits_i({s1_q[0], 16'(hs)}), .quo_o(tu_quo)
  );
  usgv_div #(.QB(17), .LAT(LAT)) u_div_tv (
    .clk_i, .en_i(en), .div_i(rd), .rem_i(CW'(r1_q[IW-1:1])),
    .bits_i({r1_q[0], 16'(hr)}), .quo_o(tv_quo)
  );

  // side fields travel next to the math; texture joins once the dividers finish
  usgv_pkg::side_t side_q [SIDE_N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{tex_u: '0, tex_v: '0, vertex_number: vn1_q, quad_start: qd1_q};
      for (int k = 1; k < SIDE_N; k++) begin
        if (k == LAT) begin
          side_q[k] <= '{tex_u: tu_quo, tex_v: tv_quo,
                         vertex_number: side_q[k-1].vertex_number,
                         quad_start: side_q[k-1].quad_start};
        end else begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  // four sine lanes: sin(pol), cos(pol), sin(azi), cos(azi)
  logic [31:0]        ph [4];
  logic signed [15:0] sn [4];

  assign ph[0] = pol_quo;
  assign ph[1] = pol_quo + usgv_pkg::Q30_ONE;
  assign ph[2] = azi_quo[31:0];
  assign ph[3] = azi_quo[31:0] + usgv_pkg::Q30_ONE;

  for (genvar ln = 0; ln < 4; ln++) begin : g_sin
    logic [30:0]        x_c;
    logic [61:0]        xx;
    logic [62:0]        xp;
    logic [30:0]        x_q  [6];
    logic [30:0]        x2_q [5];
    logic [31:0]        p_q  [5];
    logic               sg_q [7];
    logic [32:0]        qs_q;
    logic signed [15:0] sn_q;

    // fold phase into the first quarter, square it
    assign x_c = ph[ln][30] ? (31'(usgv_pkg::Q30_ONE) - {1'b0, ph[ln][29:0]})
                            : {1'b0, ph[ln][29:0]};
    assign xx  = 62'(x_c) * 62'(x_c);

    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[0]  <= x_c;
        x2_q[0] <= xx[60:30];
        sg_q[0] <= ph[ln][31];
        for (int k = 1; k < 6; k++) x_q[k] <= x_q[k-1];
        for (int k = 1; k < 5; k++) x2_q[k] <= x2_q[k-1];
        for (int k = 1; k < 7; k++) sg_q[k] <= sg_q[k-1];
      end
    end

    // Horner steps, one multiply per stage
    for (genvar h = 0; h < 5; h++) begin : g_h
      logic [31:0] pin;
      logic [62:0] pr;
      if (h == 0) begin : g_h0
        assign pin = usgv_pkg::PC11;
      end else begin : g_hn
        assign pin = p_q[h-1];
      end
      assign pr = 63'(x2_q[h]) * 63'(pin);
      always_ff @(posedge clk_i) begin
        if (en) p_q[h] <= usgv_pkg::HORNER_COEF[h] - pr[61:30];
      end
    end

    // final x * p, then round to Q1.15
    assign xp = 63'(x_q[5]) * 63'(p_q[4]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        qs_q <= xp[62:30];
        sn_q <= usgv_pkg::round_q15(qs_q, sg_q[6]);
      end
    end

    assign sn[ln] = sn_q;
  end

  // normals
  logic signed [15:0] nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= usgv_pkg::mul_q15(sn[3], sn[0]);
      ny_q <= $signed(16'(-sn[1]));
      nz_q <= usgv_pkg::mul_q15(sn[2], sn[0]);
    end
  end

  // positions and output register
  usgv_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.pos_x         <= usgv_pkg::scale_pos(nx_q, radius_q);
      out_q.pos_y         <= usgv_pkg::scale_pos(ny_q, radius_q);
      out_q.pos_z         <= usgv_pkg::scale_pos(nz_q, radius_q);
      out_q.normal_x      <= nx_q;
      out_q.normal_y      <= ny_q;
      out_q.normal_z      <= nz_q;
      out_q.tex_u         <= side_q[SIDE_N-1].tex_u;
      out_q.tex_v         <= side_q[SIDE_N-1].tex_v;
      out_q.vertex_number <= side_q[SIDE_N-1].vertex_number;
      out_q.quad_start    <= side_q[SIDE_N-1].quad_start;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### src/usgv_div.sv
// Pipelined restoring divider, two quotient bits per stage. Depends on usgv_pkg.
// The user must keep the divisor static while items are in flight (not enforced here).
`timescale 1ns / 1ps
`default_nettype none

module usgv_div #(
  parameter int unsigned QB  = 33,
  parameter int unsigned LAT = usgv_pkg::DIV_LAT
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [usgv_pkg::CW-1:0] div_i,   // divisor, at least 1
  input  logic [usgv_pkg::CW-1:0] rem_i,   // starting partial remainder, below div_i
  input  logic [QB-1:0]          bits_i,  // numerator bits still to bring down, MSB first
  output logic [QB-1:0]          quo_o
);

  localparam int unsigned DW  = usgv_pkg::CW;
  localparam int unsigned SPS = usgv_pkg::DIV_SPS;

  logic [DW-1:0] rem_q  [LAT];
  logic [QB-1:0] bits_q [LAT];
  logic [QB-1:0] quo_q  [LAT];

  for (genvar j = 0; j < LAT; j++) begin : g_st
    logic [DW-1:0] rem_in, rem_c;
    logic [QB-1:0] bits_in, bits_c, quo_in, quo_c;
    logic [DW:0]   t;

    if (j == 0) begin : g_first
      assign rem_in  = rem_i;
      assign bits_in = bits_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign bits_in = bits_q[j-1];
      assign quo_in  = quo_q[j-1];
    end

    // up to two shift-compare-subtract steps; none once all quotient bits are done
    always_comb begin
      rem_c  = rem_in;
      bits_c = bits_in;
      quo_c  = quo_in;
      t      = '0;
      for (int k = 0; k < SPS; k++) begin
        if (j * SPS + k < QB) begin
          t      = {rem_c, bits_c[QB-1]};
          bits_c = bits_c << 1;
          if (t >= {1'b0, div_i}) begin
            t     = t - {1'b0, div_i};
            quo_c = {quo_c[QB-2:0], 1'b1};
          end else begin
            quo_c = {quo_c[QB-2:0], 1'b0};
          end
          rem_c = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_c;
        bits_q[j] <= bits_c;
        quo_q[j]  <= quo_c;
      end
    end
  end

  assign quo_o = quo_q[LAT-1];

endmodule

`default_nettype wire

### tb/tb_uv_sphere_vertex_generator.sv
// Self-checking testbench for uv_sphere_vertex_generator: directed grid points,
// then random ones over several register settings, checked against a local model.
// Depends on usgv_pkg and the uv_sphere_vertex_generator RTL.
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator;

  localparam logic [usgv_pkg::AW-1:0] REG_UNUSED = 2'd3;  // no register behind this index
  localparam int unsigned GRID_MAX = 1024;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned EXP_DEPTH = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  usgv_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  usgv_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [usgv_pkg::AW-1:0] cfg_idx_i = '0;
  logic [usgv_pkg::RW-1:0] cfg_wdata_i = '0;

  uv_sphere_vertex_generator dut (.*);

  // Shadow registers
  logic [usgv_pkg::RW-1:0] radius_reg = 16'd128;
  logic [usgv_pkg::CW-1:0] rings_reg = 11'd32;
  logic [usgv_pkg::CW-1:0] sectors_reg = 11'd32;

  // Expected results in transfer order
  usgv_pkg::out_t exp_mem [EXP_DEPTH];
  int unsigned sent_n = 0;
  int unsigned got_n = 0;
  int errors = 0;
  bit quiet = 1'b0;  // no gaps on either side while set

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------- vertex model ----------------
  function automatic longint unsigned quarter_wave(longint unsigned x);
    longint unsigned x2, p;
    x2 = (x * x) >> 30;
    p = usgv_pkg::PC11;
    p = usgv_pkg::PC9 - ((x2 * p) >> 30);
    p = usgv_pkg::PC7 - ((x2 * p) >> 30);
    p = usgv_pkg::PC5 - ((x2 * p) >> 30);
    p = usgv_pkg::PC3 - ((x2 * p) >> 30);
    p = usgv_pkg::PC1 - ((x2 * p) >> 30);
    return (x * p) >> 30;
  endfunction

  function automatic int sine_of(logic [31:0] phase);
    longint unsigned x, q;
    x = phase[30] ? (64'd1 << 30) - phase[29:0] : phase[29:0];
    q = (quarter_wave(x) + 16384) >> 15;
    if (q > 32767) q = 32767;
    return phase[31] ? -int'(q) : int'(q);
  endfunction

  function automatic int frac_mul(int a, int b);
    longint unsigned m;
    m = (longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b) + 16384) >> 15;
    return ((a < 0) != (b < 0)) ? -int'(m) : int'(m);
  endfunction

  function automatic logic signed [23:0] radius_scale(int n, int unsigned rad);
    longint unsigned m;
    m = (longint'(n < 0 ? -n : n) * rad + 128) >> 8;
    if (m > 8388607) m = 8388607;
    return n < 0 ? 24'(-longint'(m)) : 24'(m);
  endfunction

  function automatic longint unsigned grid_dim(logic [usgv_pkg::CW-1:0] c);
    if (c < 2) return 2;
    if (c > GRID_MAX) return GRID_MAX;
    return c;
  endfunction

  function automatic usgv_pkg::out_t vertex_at(usgv_pkg::in_t pt);
    longint unsigned rc, sc, r, s, rd, sd;
    logic [31:0] pol, azi;
    int sp, cp, sa, ca, nx, ny, nz;
    usgv_pkg::out_t v;
    rc = grid_dim(rings_reg);
    sc = grid_dim(sectors_reg);
    r = pt.ring_index;
    s = pt.sector_index;
    if (r > rc - 1) r = rc - 1;
    if (s > sc - 1) s = sc - 1;
    rd = rc - 1;
    sd = sc - 1;
    pol = 32'(((r << 31) + rd / 2) / rd);
    azi = 32'(((s << 32) + sd / 2) / sd);
    sp = sine_of(pol);
    cp = sine_of(pol + usgv_pkg::Q30_ONE);
    sa = sine_of(azi);
    ca = sine_of(azi + usgv_pkg::Q30_ONE);
    ny = -cp;
    nx = frac_mul(ca, sp);
    nz = frac_mul(sa, sp);
    v.pos_x = radius_scale(nx, radius_reg);
    v.pos_y = radius_scale(ny, radius_reg);
    v.pos_z = radius_scale(nz, radius_reg);
    v.normal_x = 16'(nx);
    v.normal_y = 16'(ny);
    v.normal_z = 16'(nz);
    v.tex_u = 17'(((s << 16) + sd / 2) / sd);
    v.tex_v = 17'(((r << 16) + rd / 2) / rd);
    v.vertex_number = 20'(r * sc + s);
    v.quad_start = (r < rd) && (s < sd);
    return v;
  endfunction

  // ---------------- result checking ----------------
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      if (errors <= 10)
        $display("%0t %s: expected %0d, got %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    usgv_pkg::out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (got_n == sent_n) begin
        errors++;
        if (errors <= 10) $display("%0t unexpected result transfer", $realtime);
      end else begin
        e = exp_mem[got_n % EXP_DEPTH];
        got_n++;
        check_field("pos_x", e.pos_x, out_data_o.pos_x);
        check_field("pos_y", e.pos_y, out_data_o.pos_y);
        check_field("pos_z", e.pos_z, out_data_o.pos_z);
        check_field("normal_x", e.normal_x, out_data_o.normal_x);
        check_field("normal_y", e.normal_y, out_data_o.normal_y);
        check_field("normal_z", e.normal_z, out_data_o.normal_z);
        check_field("tex_u", e.tex_u, out_data_o.tex_u);
        check_field("tex_v", e.tex_v, out_data_o.tex_v);
        check_field("vertex_number", e.vertex_number, out_data_o.vertex_number);
        check_field("quad_start", e.quad_start, out_data_o.quad_start);
      end
    end
  end

  // Random gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output-side stalls
  always @(negedge clk_i) begin
    int stall;
    if (quiet) out_ready_i <= 1'b1;
    else begin
      stall = gap_len();
      if (stall == 0) out_ready_i <= 1'b1;
      else begin
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_point(usgv_pkg::in_t pt, bit typed, usgv_pkg::out_t typed_v);
    int g;
    usgv_pkg::out_t e;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = pt;
    do @(posedge clk_i); while (!in_ready_o);
    e = vertex_at(pt);
    if (typed) begin
      e.tex_u = typed_v.tex_u;
      e.tex_v = typed_v.tex_v;
      e.vertex_number = typed_v.vertex_number;
      e.quad_start = typed_v.quad_start;
    end
    exp_mem[sent_n % EXP_DEPTH] = e;
    sent_n++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (got_n != sent_n) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [usgv_pkg::AW-1:0] idx, logic [usgv_pkg::RW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    case (idx)
      usgv_pkg::REG_RADIUS:  radius_reg = val;
      usgv_pkg::REG_RINGS:   rings_reg = val[usgv_pkg::CW-1:0];
      usgv_pkg::REG_SECTORS: sectors_reg = val[usgv_pkg::CW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Directed points at the reset grid (32 x 32); typed rows hold the easy fields
  typedef struct {
    int unsigned ring;
    int unsigned sector;
    bit typed;
    int unsigned u, v, vn;
    bit qs;
  } point_row_t;

  point_row_t points[14] = '{
    '{0, 0, 1, 0, 0, 0, 1},
    '{31, 31, 1, 65536, 65536, 1023, 0},
    '{1023, 1023, 1, 65536, 65536, 1023, 0},  // both indexes saturate
    '{0, 31, 1, 65536, 0, 31, 0},
    '{31, 0, 1, 0, 65536, 992, 0},
    '{30, 30, 1, 63422, 63422, 990, 1},
    '{1023, 0, 1, 0, 65536, 992, 0},
    '{0, 1023, 1, 65536, 0, 31, 0},
    '{16, 8, 0, 0, 0, 0, 0},
    '{5, 20, 0, 0, 0, 0, 0},
    '{15, 15, 0, 0, 0, 0, 0},
    '{682, 341, 0, 0, 0, 0, 0},
    '{1, 1, 0, 0, 0, 0, 0},
    '{512, 7, 0, 0, 0, 0, 0}
  };

  // Radius, rings, sectors per phase; radius is random from phase 3, counts in phase 5
  int unsigned phase_cfg[6][3] = '{
    '{65535, 2, 2},
    '{0, 1024, 1024},
    '{256, 0, 2047},
    '{0, 1, 1025},
    '{0, 3, 5},
    '{0, 0, 0}
  };

  initial begin
    usgv_pkg::in_t pt;
    usgv_pkg::out_t tv;
    int unsigned rc, sc;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (points[i]) begin
      pt.ring_index = usgv_pkg::IW'(points[i].ring);
      pt.sector_index = usgv_pkg::IW'(points[i].sector);
      tv = '0;
      tv.tex_u = 17'(points[i].u);
      tv.tex_v = 17'(points[i].v);
      tv.vertex_number = 20'(points[i].vn);
      tv.quad_start = points[i].qs;
      send_point(pt, points[i].typed, tv);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(usgv_pkg::REG_RADIUS,
                ph >= 3 ? usgv_pkg::RW'($urandom) : usgv_pkg::RW'(phase_cfg[ph][0]));
      write_reg(usgv_pkg::REG_RINGS, ph == 5 ? usgv_pkg::RW'($urandom_range(2, 64))
                                             : usgv_pkg::RW'(phase_cfg[ph][1]));
      write_reg(usgv_pkg::REG_SECTORS, ph == 5 ? usgv_pkg::RW'($urandom_range(2, 64))
                                               : usgv_pkg::RW'(phase_cfg[ph][2]));
      if (ph == 2) write_reg(REG_UNUSED, usgv_pkg::RW'($urandom));
      quiet = (ph == 1);
      rc = 32'(grid_dim(rings_reg));
      sc = 32'(grid_dim(sectors_reg));
      for (int n = 0; n < 172; n++) begin
        // mostly on-grid points, some arbitrary indexes
        if ($urandom_range(0, 4) != 0) begin
          pt.ring_index = usgv_pkg::IW'($urandom_range(0, rc - 1));
          pt.sector_index = usgv_pkg::IW'($urandom_range(0, sc - 1));
        end else begin
          pt = usgv_pkg::in_t'($urandom);
        end
        send_point(pt, 1'b0, tv);
        if (ph == 4 && n == 80) drain();  // hold off until the pipeline is empty
      end
      drain();
    end

    if (errors == 0) $display("uv_sphere_vertex_generator: match");
    else $display("uv_sphere_vertex_generator: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("uv_sphere_vertex_generator: mismatch");
    $finish;
  end

endmodule

### sim.f
src/usgv_pkg.sv
src/usgv_div.sv
src/uv_sphere_vertex_generator.sv
tb/tb_uv_sphere_vertex_generator.sv
